// ===== hw/rtl/cbd_pkg.sv =====
// Shared types and constants of the coherent binary demodulator.
`timescale 1ns / 1ps

package cbd_pkg;

    // Sample and accumulator widths.
    localparam int SAMPLE_WIDTH = 16;
    localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH;
    localparam int ACC_WIDTH    = 48;

    // Bit period limits.
    localparam int MAX_SAMPLES_PER_BIT = 1024;
    localparam int LEN_WIDTH           = 11;
    localparam int CNT_WIDTH           = $clog2(MAX_SAMPLES_PER_BIT);

    // Configuration port.
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = ACC_WIDTH;
    localparam logic [LEN_WIDTH-1:0] SPB_RESET = LEN_WIDTH'(100);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_DUAL_MODE       = 2'd0,
        CFG_SAMPLES_PER_BIT = 2'd1,
        CFG_THRESHOLD       = 2'd2
    } cbd_cfg_idx_t;

    // Settings in force, as seen by the datapath.
    typedef struct packed {
        logic                        dual_mode;
        logic [LEN_WIDTH-1:0]        bit_len;
        logic signed [ACC_WIDTH-1:0] threshold;
    } cbd_cfg_t;

    // Finished sums of one bit period, handed from the integrator to the slicer.
    typedef struct packed {
        logic                 valid;
        logic [ACC_WIDTH-1:0] acc_a;
        logic [ACC_WIDTH-1:0] acc_b;
    } cbd_sums_t;

endpackage

// ===== hw/rtl/cbd_mac.sv =====
// Input register, product stage and integrate-and-dump accumulators.
`timescale 1ns / 1ps

module cbd_mac import cbd_pkg::*; (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_rx_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] s_ref_a,
    input  logic signed [SAMPLE_WIDTH-1:0] s_ref_b,
    input  cbd_cfg_t                       cfg,
    output cbd_sums_t                      sums,
    input  logic                           sums_ready
);

    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] rx_reg, ref_a_reg, ref_b_reg;
    logic                           prod_valid_reg;
    logic signed [PROD_WIDTH-1:0]   prod_a_reg, prod_b_reg;
    logic [ACC_WIDTH-1:0]           acc_a_reg, acc_b_reg;
    logic [ACC_WIDTH-1:0]           dump_a_reg, dump_b_reg;
    logic                           dump_valid_reg, dump_valid_next;
    logic [CNT_WIDTH-1:0]           count_reg;

    logic                 dump_ready, prod_ready, in_ready;
    logic                 take, last;
    logic [ACC_WIDTH-1:0] sum_a, sum_b;

    // Each stage moves on when it is empty or its successor moves on.
    assign dump_ready = !dump_valid_reg || sums_ready;
    assign prod_ready = !prod_valid_reg || dump_ready;
    assign in_ready   = !in_valid_reg || prod_ready;
    assign s_ready    = in_ready;

    // Sample count and running sums.
    assign take  = prod_valid_reg && dump_ready;
    assign last  = (LEN_WIDTH'(count_reg) + LEN_WIDTH'(1)) >= cfg.bit_len;
    assign sum_a = acc_a_reg + ACC_WIDTH'(prod_a_reg);
    assign sum_b = acc_b_reg + ACC_WIDTH'(prod_b_reg);

    assign dump_valid_next = (dump_valid_reg && !sums_ready) || (take && last);

    // Valid flags, count and accumulators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            dump_valid_reg <= 1'b0;
            count_reg      <= '0;
            acc_a_reg      <= '0;
            acc_b_reg      <= '0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_valid;
            end
            if (prod_ready) begin
                prod_valid_reg <= in_valid_reg;
            end
            dump_valid_reg <= dump_valid_next;
            if (take) begin
                if (last) begin
                    count_reg <= '0;
                    acc_a_reg <= '0;
                    acc_b_reg <= '0;
                end else begin
                    count_reg <= count_reg + CNT_WIDTH'(1);
                    acc_a_reg <= sum_a;
                    acc_b_reg <= sum_b;
                end
            end
        end
    end

    // Sample, product and dump payload.
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rx_reg    <= s_rx_sample;
            ref_a_reg <= s_ref_a;
            ref_b_reg <= s_ref_b;
        end
        if (prod_ready) begin
            prod_a_reg <= rx_reg * ref_a_reg;
            prod_b_reg <= rx_reg * ref_b_reg;
        end
        if (take && last) begin
            dump_a_reg <= sum_a;
            dump_b_reg <= sum_b;
        end
    end

    assign sums.valid = dump_valid_reg;
    assign sums.acc_a = dump_a_reg;
    assign sums.acc_b = dump_b_reg;

endmodule

// ===== hw/rtl/cbd_decide.sv =====
// Correlation select and threshold decision with the result register.
`timescale 1ns / 1ps

module cbd_decide import cbd_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cbd_cfg_t                    cfg,
    input  cbd_sums_t                   sums,
    output logic                        sums_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_bit_value,
    output logic signed [ACC_WIDTH-1:0] m_correlation
);

    logic                        corr_valid_reg;
    logic signed [ACC_WIDTH-1:0] corr_reg;
    logic                        out_valid_reg;
    logic                        bit_reg;
    logic signed [ACC_WIDTH-1:0] out_corr_reg;
    logic                        out_ready;

    assign out_ready  = !out_valid_reg || m_ready;
    assign sums_ready = !corr_valid_reg || out_ready;

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corr_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (sums_ready) begin
                corr_valid_reg <= sums.valid;
            end
            if (out_ready) begin
                out_valid_reg <= corr_valid_reg;
            end
        end
    end

    // In dual mode the correlation is the B sum minus the A sum.
    always_ff @(posedge aclk) begin
        if (sums_ready) begin
            corr_reg <= cfg.dual_mode ? $signed(sums.acc_b - sums.acc_a) : $signed(sums.acc_a);
        end
        if (out_ready) begin
            out_corr_reg <= corr_reg;
            bit_reg      <= corr_reg > cfg.threshold;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_bit_value   = bit_reg;
    assign m_correlation = out_corr_reg;

endmodule

// ===== hw/rtl/coherent_binary_demodulator_top.sv =====
// Top level of the coherent binary demodulator: configuration registers and datapath.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_rx_sample, s_ref_a, s_ref_b
//   m_       out        m_valid / m_ready    m_bit_value, m_correlation
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample transfer is taken every cycle while s_ready is high. The last sample of a bit
// period passes in turn the input register, the 16x16 product register, the 48-bit
// accumulate and dump register and the correlation select register; its bit decision is
// then offered from the decision register.
// Reset (aresetn, synchronous) empties every stage, clears the sums and count and
// loads the register defaults. A stall on m_ready fills the stages one by one before
// s_ready drops; configuration writes are always ready.
`timescale 1ns / 1ps

module coherent_binary_demodulator_top import cbd_pkg::*; (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_rx_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] s_ref_a,
    input  logic signed [SAMPLE_WIDTH-1:0] s_ref_b,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_bit_value,
    output logic signed [ACC_WIDTH-1:0]    m_correlation,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]      cfg_data
);

    logic                        dual_mode_reg;
    logic [LEN_WIDTH-1:0]        spb_reg;
    logic signed [ACC_WIDTH-1:0] threshold_reg;
    cbd_cfg_t                    cfg;
    cbd_sums_t                   sums;
    logic                        sums_ready;

    assign cfg_ready = 1'b1;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dual_mode_reg <= 1'b0;
            spb_reg       <= SPB_RESET;
            threshold_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cbd_cfg_idx_t'(cfg_index))
                CFG_DUAL_MODE:       dual_mode_reg <= cfg_data[0];
                CFG_SAMPLES_PER_BIT: spb_reg       <= cfg_data[LEN_WIDTH-1:0];
                CFG_THRESHOLD:       threshold_reg <= $signed(cfg_data[ACC_WIDTH-1:0]);
                default: ;
            endcase
        end
    end

    // A zero length acts as one sample; lengths above the maximum are clamped.
    always_comb begin
        cfg.dual_mode = dual_mode_reg;
        cfg.threshold = threshold_reg;
        if (spb_reg == '0) begin
            cfg.bit_len = LEN_WIDTH'(1);
        end else if (spb_reg > LEN_WIDTH'(MAX_SAMPLES_PER_BIT)) begin
            cfg.bit_len = LEN_WIDTH'(MAX_SAMPLES_PER_BIT);
        end else begin
            cfg.bit_len = spb_reg;
        end
    end

    cbd_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_sample (s_rx_sample),
        .s_ref_a     (s_ref_a),
        .s_ref_b     (s_ref_b),
        .cfg         (cfg),
        .sums        (sums),
        .sums_ready  (sums_ready)
    );

    cbd_decide u_decide (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .sums          (sums),
        .sums_ready    (sums_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bit_value   (m_bit_value),
        .m_correlation (m_correlation)
    );

endmodule

// ===== hw/rtl/cbd_checker.sv =====
// Port-level checks of the coherent binary demodulator and their binding.
`timescale 1ns / 1ps

module cbd_checker import cbd_pkg::*; (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic signed [SAMPLE_WIDTH-1:0] s_rx_sample,
    input logic signed [SAMPLE_WIDTH-1:0] s_ref_a,
    input logic signed [SAMPLE_WIDTH-1:0] s_ref_b,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_bit_value,
    input logic signed [ACC_WIDTH-1:0]    m_correlation
);

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A free output side lets every stage move, so the input side is free as well.
    a_ready_chain: assert property (@(posedge aclk) m_ready |-> s_ready)
        else $error("input stalled while result side is ready");

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // A stalled result keeps its payload.
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_correlation) && $stable(m_bit_value))
        else $error("result payload changed while stalled");

    // A waiting sample stays offered with its payload unchanged.
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_rx_sample) && $stable(s_ref_a)
            && $stable(s_ref_b))
        else $error("sample changed before transfer");

endmodule

bind coherent_binary_demodulator_top cbd_checker u_cbd_checker (.*);

// ===== tb/sv/coherent_binary_demodulator_top_tb.sv =====
// Self-checking testbench for the coherent binary demodulator top level.
`timescale 1ns / 1ps

module coherent_binary_demodulator_top_tb import cbd_pkg::*;;

    localparam int          CLK_HALF_NS   = 6;
    localparam int          RESET_CYCLES  = 9;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          MAX_REPORTS   = 10;
    localparam int          TARGET_ITEMS  = 1800;
    localparam int          TARGET_BITS   = 48;
    localparam int unsigned LIMIT_NS      = 5_000_000;

    // Index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NO_REG = 2'd3;

    localparam logic signed [ACC_WIDTH-1:0] THRESH_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_WIDTH-1:0] THRESH_MIN = 48'sh8000_0000_0000;

    typedef struct {
        logic                           bit_value;
        logic signed [ACC_WIDTH-1:0]    correlation;
    } decision_t;

    typedef struct {
        logic                           is_cfg;
        logic [CFG_INDEX_WIDTH-1:0]     idx;
        logic [CFG_DATA_WIDTH-1:0]      data;
        logic signed [SAMPLE_WIDTH-1:0] rx;
        logic signed [SAMPLE_WIDTH-1:0] ra;
        logic signed [SAMPLE_WIDTH-1:0] rb;
        logic                           typed;
        logic                           exp_bit;
        logic signed [ACC_WIDTH-1:0]    exp_corr;
    } dir_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic signed [SAMPLE_WIDTH-1:0] s_rx_sample;
    logic signed [SAMPLE_WIDTH-1:0] s_ref_a;
    logic signed [SAMPLE_WIDTH-1:0] s_ref_b;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic                           m_bit_value;
    logic signed [ACC_WIDTH-1:0]    m_correlation;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]     cfg_index;
    logic [CFG_DATA_WIDTH-1:0]      cfg_data;

    // Predictor copy of the registers and the integrator state.
    logic                           mdl_dual;
    logic [LEN_WIDTH-1:0]           mdl_bit_len;
    logic signed [ACC_WIDTH-1:0]    mdl_thresh;
    int unsigned                    mdl_count;
    logic signed [ACC_WIDTH-1:0]    mdl_sum_a;
    logic signed [ACC_WIDTH-1:0]    mdl_sum_b;

    decision_t   pending_decisions[$];
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned samples_sent    = 0;
    int unsigned decisions_seen  = 0;
    int unsigned failures        = 0;

    coherent_binary_demodulator_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_sample   (s_rx_sample),
        .s_ref_a       (s_ref_a),
        .s_ref_b       (s_ref_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bit_value   (m_bit_value),
        .m_correlation (m_correlation),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #(LIMIT_NS);
        $display("coherent_binary_demodulator_top_tb: FAIL");
        $finish;
    end

    // Result channel back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [CFG_DATA_WIDTH-1:0] rand48();
        rand48 = {16'($urandom()), $urandom()};
    endfunction

    // One of the corner values of a sample.
    function automatic logic signed [SAMPLE_WIDTH-1:0] corner_sample();
        case ($urandom_range(0, 4))
            0: corner_sample = 16'sh8000;
            1: corner_sample = 16'sh7FFF;
            2: corner_sample = -16'sd1;
            3: corner_sample = 16'sd1;
            default: corner_sample = 16'sd0;
        endcase
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                         input logic [CFG_DATA_WIDTH-1:0] data);
        dir_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic dir_row_t smp_row(input logic signed [SAMPLE_WIDTH-1:0] rx,
                                         input logic signed [SAMPLE_WIDTH-1:0] ra,
                                         input logic signed [SAMPLE_WIDTH-1:0] rb);
        dir_row_t r;
        r = '{default: '0};
        r.rx = rx;
        r.ra = ra;
        r.rb = rb;
        return r;
    endfunction

    function automatic dir_row_t chk_row(input logic signed [SAMPLE_WIDTH-1:0] rx,
                                         input logic signed [SAMPLE_WIDTH-1:0] ra,
                                         input logic signed [SAMPLE_WIDTH-1:0] rb,
                                         input logic exp_bit,
                                         input logic signed [ACC_WIDTH-1:0] exp_corr);
        dir_row_t r;
        r = smp_row(rx, ra, rb);
        r.typed    = 1'b1;
        r.exp_bit  = exp_bit;
        r.exp_corr = exp_corr;
        return r;
    endfunction

    // Integrate one sample and, at the end of a bit period, form the decision.
    function automatic void correlate_sample(input logic signed [SAMPLE_WIDTH-1:0] rx,
                                             input logic signed [SAMPLE_WIDTH-1:0] ra,
                                             input logic signed [SAMPLE_WIDTH-1:0] rb,
                                             output logic done,
                                             output decision_t dec);
        logic signed [ACC_WIDTH-1:0] prod_a;
        logic signed [ACC_WIDTH-1:0] prod_b;
        logic signed [ACC_WIDTH-1:0] corr;
        int unsigned                 len;
        prod_a = ACC_WIDTH'(rx) * ACC_WIDTH'(ra);
        prod_b = ACC_WIDTH'(rx) * ACC_WIDTH'(rb);
        len = 32'(mdl_bit_len);
        if (len == 0) begin
            len = 1;
        end
        if (len > MAX_SAMPLES_PER_BIT) begin
            len = MAX_SAMPLES_PER_BIT;
        end
        mdl_sum_a = mdl_sum_a + prod_a;
        mdl_sum_b = mdl_sum_b + prod_b;
        done = 1'b0;
        dec  = '{bit_value: 1'b0, correlation: '0};
        if (mdl_count + 1 < len) begin
            mdl_count++;
        end else begin
            corr = mdl_dual ? (mdl_sum_b - mdl_sum_a) : mdl_sum_a;
            dec.bit_value   = (corr > mdl_thresh);
            dec.correlation = corr;
            done      = 1'b1;
            mdl_count = 0;
            mdl_sum_a = '0;
            mdl_sum_b = '0;
        end
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Stop sending and wait until every expected decision has been delivered.
    task automatic settle_pipeline();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_decisions.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Register write; the predictor takes the value once the transfer happens.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge aclk);
            took = cfg_ready;
            @(negedge aclk);
        end while (!took);
        case (idx)
            CFG_DUAL_MODE:       mdl_dual    = data[0];
            CFG_SAMPLES_PER_BIT: mdl_bit_len = data[LEN_WIDTH-1:0];
            CFG_THRESHOLD:       mdl_thresh  = data;
            default: ;
        endcase
    endtask

    // Offer one sample; called and returning at a falling edge, valid left high.
    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] rx,
                               input logic signed [SAMPLE_WIDTH-1:0] ra,
                               input logic signed [SAMPLE_WIDTH-1:0] rb,
                               input logic typed,
                               input logic exp_bit,
                               input logic signed [ACC_WIDTH-1:0] exp_corr);
        logic      took;
        logic      done;
        decision_t dec;
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_rx_sample <= rx;
        s_ref_a     <= ra;
        s_ref_b     <= rb;
        do begin
            @(posedge aclk);
            took = s_ready;
            if (took) begin
                correlate_sample(rx, ra, rb, done, dec);
                if (typed) begin
                    dec = '{bit_value: exp_bit, correlation: exp_corr};
                end
                if (done) begin
                    pending_decisions.push_back(dec);
                end
                samples_sent++;
            end
            @(negedge aclk);
        end while (!took);
    endtask

    // Result checker: each transfer against the oldest expected decision.
    always @(posedge aclk) begin : check_decision
        decision_t want;
        if (aresetn && m_valid && m_ready) begin
            decisions_seen++;
            if (pending_decisions.size() == 0) begin
                note_failure($sformatf("unexpected decision bit=%0b corr=%0d",
                                       m_bit_value, m_correlation));
            end else begin
                want = pending_decisions.pop_front();
                if (m_bit_value !== want.bit_value || m_correlation !== want.correlation) begin
                    note_failure($sformatf("bit exp=%0b got=%0b, corr exp=%0d got=%0d",
                                           want.bit_value, m_bit_value,
                                           want.correlation, m_correlation));
                end
            end
        end
    end

    // Main sequence: reset, directed table, then randomized phases.
    initial begin
        dir_row_t                       rows[$];
        int unsigned                    phase;
        int unsigned                    phase_items;
        int unsigned                    pick;
        logic                           large_phase;
        logic [CFG_DATA_WIDTH-1:0]      wdata;
        logic signed [ACC_WIDTH-1:0]    th;
        logic signed [SAMPLE_WIDTH-1:0] rx;
        logic signed [SAMPLE_WIDTH-1:0] ra;
        logic signed [SAMPLE_WIDTH-1:0] rb;
        logic                           sym;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_rx_sample = '0;
        s_ref_a     = '0;
        s_ref_b     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;

        mdl_dual    = 1'b0;
        mdl_bit_len = SPB_RESET;
        mdl_thresh  = '0;
        mdl_count   = 0;
        mdl_sum_a   = '0;
        mdl_sum_b   = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Single mode at reset mode and threshold, one sample per bit.
        rows.push_back(cfg_row(CFG_SAMPLES_PER_BIT, 48'd1));
        rows.push_back(chk_row(16'sh7FFF, 16'sh7FFF, 16'sd0, 1'b1, 48'sd1073676289));
        rows.push_back(chk_row(16'sh8000, 16'sh8000, 16'sd0, 1'b1, 48'sd1073741824));
        rows.push_back(chk_row(16'sh8000, 16'sh7FFF, 16'sd0, 1'b0, -48'sd1073709056));
        // Correlation equal to the threshold gives zero; ref_b unused in single mode.
        rows.push_back(chk_row(16'sd0, 16'sd0, 16'sh8000, 1'b0, 48'sd0));
        // A zero bit length behaves as one sample per bit.
        rows.push_back(cfg_row(CFG_SAMPLES_PER_BIT, 48'd0));
        rows.push_back(chk_row(16'sd1, 16'sd1, 16'sd0, 1'b1, 48'sd1));
        // Dual mode: sum for B minus sum for A.
        rows.push_back(cfg_row(CFG_DUAL_MODE, 48'd1));
        rows.push_back(chk_row(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, 48'sd2147385345));
        rows.push_back(chk_row(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1, 48'sd2147450880));
        rows.push_back(chk_row(16'sd1, 16'sd5, 16'sd2, 1'b0, -48'sd3));
        // Threshold extremes.
        rows.push_back(cfg_row(CFG_THRESHOLD, THRESH_MAX));
        rows.push_back(chk_row(16'sh7FFF, 16'sd0, 16'sh7FFF, 1'b0, 48'sd1073676289));
        rows.push_back(cfg_row(CFG_THRESHOLD, THRESH_MIN));
        rows.push_back(chk_row(16'sd0, 16'sh7FFF, 16'sh8000, 1'b1, 48'sd0));
        // A write to an index with no register changes nothing.
        rows.push_back(cfg_row(CFG_NO_REG, 48'h7FFF_FFFF_FFFF));
        rows.push_back(chk_row(16'sd1, 16'sd0, 16'sd1, 1'b1, 48'sd1));
        // Bit length shortened in the middle of a bit.
        rows.push_back(cfg_row(CFG_DUAL_MODE, 48'd0));
        rows.push_back(cfg_row(CFG_THRESHOLD, 48'd0));
        rows.push_back(cfg_row(CFG_SAMPLES_PER_BIT, 48'd3));
        rows.push_back(smp_row(16'sd1200, -16'sd700, 16'sd31000));
        rows.push_back(smp_row(-16'sd9000, 16'sd4000, -16'sd25));
        rows.push_back(cfg_row(CFG_SAMPLES_PER_BIT, 48'd2));
        rows.push_back(smp_row(16'sd300, 16'sd300, -16'sd300));
        // Mode switched in the middle of a bit.
        rows.push_back(smp_row(16'sh7FFF, 16'sh8000, 16'sh7FFF));
        rows.push_back(cfg_row(CFG_DUAL_MODE, 48'd1));
        rows.push_back(smp_row(-16'sd12345, 16'sd2222, 16'sd30000));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                settle_pipeline();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                send_sample(rows[i].rx, rows[i].ra, rows[i].rb,
                            rows[i].typed, rows[i].exp_bit, rows[i].exp_corr);
            end
        end

        // Random phases, each with a new idling pattern and with settings that may be rewritten.
        phase = 0;
        while (samples_sent < TARGET_ITEMS || decisions_seen < TARGET_BITS) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            large_phase = (phase == 2);
            settle_pipeline();

            // Settings change only while the datapath is empty.
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_DUAL_MODE, rand48());
            end
            if (large_phase || $urandom_range(0, 9) < 7) begin
                wdata = rand48();
                pick = $urandom_range(0, 99);
                if (large_phase) begin
                    wdata[LEN_WIDTH-1:0] = LEN_WIDTH'($urandom_range(1024, 2047));
                end else if (pick < 5) begin
                    wdata[LEN_WIDTH-1:0] = '0;
                end else if (pick < 75) begin
                    wdata[LEN_WIDTH-1:0] = LEN_WIDTH'($urandom_range(1, 8));
                end else if (pick < 95) begin
                    wdata[LEN_WIDTH-1:0] = LEN_WIDTH'($urandom_range(9, 40));
                end else begin
                    wdata[LEN_WIDTH-1:0] = LEN_WIDTH'($urandom_range(41, 100));
                end
                write_reg(CFG_SAMPLES_PER_BIT, wdata);
            end
            if ($urandom_range(0, 1) == 1) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    th = '0;
                end else if (pick < 20) begin
                    th = THRESH_MAX;
                end else if (pick < 25) begin
                    th = THRESH_MIN;
                end else if (pick < 75) begin
                    th = ACC_WIDTH'($signed($urandom()));
                    th = th >>> $urandom_range(0, 6);
                end else begin
                    th = rand48();
                end
                write_reg(CFG_THRESHOLD, th);
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg(CFG_NO_REG, rand48());
            end

            phase_items = large_phase ? 1030 + $urandom_range(0, 20) : $urandom_range(5, 40);
            repeat (phase_items) begin
                // Now and then hold off until every pending decision is out.
                if ($urandom_range(0, 149) == 0) begin
                    settle_pipeline();
                end
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    rx = SAMPLE_WIDTH'($urandom());
                    ra = SAMPLE_WIDTH'($urandom());
                    rb = SAMPLE_WIDTH'($urandom());
                end else if (pick < 85) begin
                    rx = corner_sample();
                    ra = corner_sample();
                    rb = corner_sample();
                end else begin
                    // Antipodal carrier with a little noise on the received sample.
                    sym = 1'($urandom_range(0, 1));
                    ra  = SAMPLE_WIDTH'($urandom());
                    rb  = -ra;
                    rx  = (sym ? ra : -ra) ^ SAMPLE_WIDTH'($urandom_range(0, 63));
                end
                send_sample(rx, ra, rb, 1'b0, 1'b0, '0);
            end
            phase++;
        end

        settle_pipeline();
        $display("Covered %0d samples over %0d random phases and %0d bit decisions,",
                 samples_sent, phase, decisions_seen);
        $display("with both correlator modes, zero to oversized bit lengths and threshold extremes.");
        if (failures == 0 && pending_decisions.size() == 0) begin
            $display("coherent_binary_demodulator_top_tb: PASS");
        end else begin
            $display("coherent_binary_demodulator_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cbd_pkg.sv
hw/rtl/cbd_mac.sv
hw/rtl/cbd_decide.sv
hw/rtl/coherent_binary_demodulator_top.sv
hw/rtl/cbd_checker.sv
tb/sv/coherent_binary_demodulator_top_tb.sv
